### hw/rtl/vvu_pkg.sv
`timescale 1ns / 1ps
// vvu_pkg: shared types and constants of the velocity to unicycle converter.
package vvu_pkg;

  // datapath widths
  localparam int XW       = 36;  // CORDIC vector words, Q.16 signed
  localparam int ZW       = 28;  // CORDIC angle, Q.24 radians signed
  localparam int MW       = 34;  // projected component magnitudes
  localparam int SQ_STEPS = 32;  // root bits of the vector length
  localparam int SQ_REM_W = 34;
  localparam int CL_Q_W   = 33;  // clamp quotient bits
  localparam int TR_NUM_W = 56;
  localparam int TR_DEN_W = 39;
  localparam int TR_Q_W   = 33;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [ZW-1:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic [29:0] KINV_Q30    = 30'd652032874;
  localparam logic [21:0] RAD2DEG_Q16 = 22'd3754936;

  localparam logic [14:0] SPEED_LIMIT_RST   = 15'd100;
  localparam logic [14:0] TURN_DISTANCE_RST = 15'd10;

  // round(atan(2^-i) * 2^24)
  localparam logic [23:0] ATAN_Q24 [ATAN_ENTRIES] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
    24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
  };

  typedef enum logic {
    REG_SPEED_LIMIT   = 1'b0,
    REG_TURN_DISTANCE = 1'b1
  } vvu_reg_t;

  // heading-frame components after gain correction
  typedef struct packed {
    logic          fneg;
    logic [MW-1:0] fmag;
    logic          lneg;
    logic [MW-1:0] lmag;
  } vvu_proj_t;

  // one component travelling beside its clamp division
  typedef struct packed {
    logic          clamp;
    logic          neg;
    logic [MW-1:0] mag;
  } vvu_side_t;

  // carried beside the turn-rate division
  typedef struct packed {
    logic        lneg;
    logic [15:0] fs;
  } vvu_tail_t;

endpackage

### hw/rtl/vvu_div.sv
`timescale 1ns / 1ps
// vvu_div: pipelined restoring divider, one quotient bit per stage.
module vvu_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int Q_W   = 33,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic [Q_W-1:0]   quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [DEN_W-1:0] den_o,
  output logic [SB_W-1:0]  sb_o
);

  // needs num_i < den_i * 2^Q_W
  logic [DEN_W-1:0] rem_r [1:Q_W];
  logic [Q_W-1:0]   q_r   [1:Q_W];
  logic [Q_W-1:0]   nlo_r [1:Q_W];
  logic [DEN_W-1:0] den_r [1:Q_W];
  logic [SB_W-1:0]  sb_r  [1:Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [DEN_W-1:0] p_rem;
    logic [DEN_W-1:0] p_den;
    logic [Q_W-1:0]   p_q;
    logic [Q_W-1:0]   p_n;
    logic [SB_W-1:0]  p_sb;
    logic [DEN_W:0]   t;
    logic             ge;

    if (j == 0) begin : g_first
      assign p_rem = DEN_W'(num_i >> Q_W);
      assign p_den = den_i;
      assign p_q   = '0;
      assign p_n   = num_i[Q_W-1:0];
      assign p_sb  = sb_i;
    end else begin : g_next
      assign p_rem = rem_r[j];
      assign p_den = den_r[j];
      assign p_q   = q_r[j];
      assign p_n   = nlo_r[j];
      assign p_sb  = sb_r[j];
    end

    assign t  = {p_rem, p_n[Q_W-1-j]};
    assign ge = t >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= ge ? DEN_W'(t - {1'b0, p_den}) : t[DEN_W-1:0];
        q_r[j+1]   <= {p_q[Q_W-2:0], ge};
        nlo_r[j+1] <= p_n;
        den_r[j+1] <= p_den;
        sb_r[j+1]  <= p_sb;
      end
    end
  end

  assign quo_o = q_r[Q_W];
  assign rem_o = rem_r[Q_W];
  assign den_o = den_r[Q_W];
  assign sb_o  = sb_r[Q_W];

endmodule

### hw/rtl/velocity_vector_to_unicycle.sv
`timescale 1ns / 1ps
// velocity_vector_to_unicycle: planar velocity vector to forward speed and turn rate.
//
// channel | dir | handshake          | data
// --------+-----+--------------------+----------------------------------------------
// in_     | in  | in_tvalid/tready   | heading, vel_x, vel_y (48 bit word)
// out_    | out | out_tvalid/tready  | forward_speed, turn_rate (48 bit word)
// cfg_    | in  | cfg_valid/ready    | cfg_addr picks the register, cfg_data[14:0]
//
// One word in and one word out per cycle while out_tready is high. 106 register stages
// from the input register to the output register, set by the 32-step length square
// root, the two 33-step divider chains (clamp rescale, turn-rate division) and the
// rounding stages between them.
// Reset (rst_n low, synchronous) empties the pipe and restores the registers.
// When out_tready is low with a word waiting, the whole pipe holds and in_tready drops.
module velocity_vector_to_unicycle #(
  parameter int CORDIC_STAGES = 16  // 8 .. 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] heading, [31:16] vel_x, [47:32] vel_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] forward_speed, [47:16] turn_rate
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int N       = CORDIC_STAGES;
  localparam int XW      = vvu_pkg::XW;
  localparam int ZW      = vvu_pkg::ZW;
  localparam int MW      = vvu_pkg::MW;
  localparam int SQ      = vvu_pkg::SQ_STEPS;
  localparam int RW      = vvu_pkg::SQ_REM_W;
  localparam int IDX_SQ  = 2 + SQ;            // square root done
  localparam int DLY     = IDX_SQ - (N + 4);  // aligns projections to the root
  localparam int LAT     = IDX_SQ + 1 + vvu_pkg::CL_Q_W + 3 + vvu_pkg::TR_Q_W + 2;

  // whole pipe moves together; the last stage is the output register
  logic en;
  logic vld_r [LAT];

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  logic [14:0] speed_limit_r;
  logic [29:0] lim_sq_r;
  logic [vvu_pkg::TR_DEN_W-1:0] tr_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r   <= vvu_pkg::SPEED_LIMIT_RST;
      lim_sq_r        <= 30'(vvu_pkg::SPEED_LIMIT_RST) * 30'(vvu_pkg::SPEED_LIMIT_RST);
      tr_den_r        <= {vvu_pkg::TURN_DISTANCE_RST, 24'd0};
    end else if (cfg_valid) begin
      unique case (vvu_pkg::vvu_reg_t'(cfg_addr))
        vvu_pkg::REG_SPEED_LIMIT: begin
          speed_limit_r <= cfg_data[14:0];
          lim_sq_r      <= 30'(cfg_data[14:0]) * 30'(cfg_data[14:0]);
        end
        vvu_pkg::REG_TURN_DISTANCE: begin
          // zero distance acts as one
          tr_den_r <= {(cfg_data[14:0] == 15'd0) ? 15'd1 : cfg_data[14:0], 24'd0};
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // ---------------------------------------------------------------- input word
  logic signed [15:0] h_r, vx_r, vy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h_r  <= in_tdata[15:0];
      vx_r <= in_tdata[31:16];
      vy_r <= in_tdata[47:32];
    end
  end

  // ---------------------------------------------------------------- fold into +-pi/2
  logic signed [XW-1:0] cx_r [0:N];
  logic signed [XW-1:0] cy_r [0:N];
  logic signed [ZW-1:0] cz_r [0:N];
  logic [31:0] sqx_r, sqy_r;

  logic signed [ZW-1:0] z_w;
  logic signed [XW-1:0] x_w, y_w;

  assign z_w = {{(ZW-27){h_r[15]}}, h_r, 11'd0};
  assign x_w = {{(XW-32){vx_r[15]}}, vx_r, 16'd0};
  assign y_w = {{(XW-32){vy_r[15]}}, vy_r, 16'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      // headings past a quarter turn: rotate by pi and flip the vector
      if (z_w > vvu_pkg::HALF_PI_Q24) begin
        cz_r[0] <= -(z_w - vvu_pkg::PI_Q24);
        cx_r[0] <= -x_w;
        cy_r[0] <= -y_w;
      end else if (z_w < -vvu_pkg::HALF_PI_Q24) begin
        cz_r[0] <= -(z_w + vvu_pkg::PI_Q24);
        cx_r[0] <= -x_w;
        cy_r[0] <= -y_w;
      end else begin
        cz_r[0] <= -z_w;
        cx_r[0] <= x_w;
        cy_r[0] <= y_w;
      end
      sqx_r <= 32'(unsigned'(32'(vx_r * vx_r)));
      sqy_r <= 32'(unsigned'(32'(vy_r * vy_r)));
    end
  end

  // ---------------------------------------------------------------- CORDIC rotation
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] ang;

    assign dx  = cx_r[i] >>> 0;
    assign dy  = cy_r[i] >>> i;
    assign ang = signed'({{(ZW-24){1'b0}}, vvu_pkg::ATAN_Q24[i]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cz_r[i][ZW-1]) begin
          cx_r[i+1] <= cx_r[i] - dy;
          cy_r[i+1] <= cy_r[i] + (dx >>> i);
          cz_r[i+1] <= cz_r[i] - ang;
        end else begin
          cx_r[i+1] <= cx_r[i] + dy;
          cy_r[i+1] <= cy_r[i] - (dx >>> i);
          cz_r[i+1] <= cz_r[i] + ang;
        end
      end
    end
  end

  // ---------------------------------------------------------------- gain correction
  logic          km_fneg_r, km_lneg_r;
  logic [XW-2:0] km_fmag_r, km_lmag_r;
  logic [47:0]   pf_lo_r, pl_lo_r;
  logic [46:0]   pf_hi_r, pl_hi_r;
  logic          pp_fneg_r, pp_lneg_r;
  vvu_pkg::vvu_proj_t proj_r;

  logic [XW-1:0] fmag_w, lmag_w;
  logic [64:0]   fsum_w, lsum_w;

  assign fmag_w = cx_r[N][XW-1] ? XW'(-cx_r[N]) : XW'(cx_r[N]);
  assign lmag_w = cy_r[N][XW-1] ? XW'(-cy_r[N]) : XW'(cy_r[N]);
  assign fsum_w = 65'(pf_lo_r) + (65'(pf_hi_r) << 18) + 65'(30'd536870912);
  assign lsum_w = 65'(pl_lo_r) + (65'(pl_hi_r) << 18) + 65'(30'd536870912);

  always_ff @(posedge clk) begin
    if (en) begin
      km_fneg_r <= cx_r[N][XW-1];
      km_lneg_r <= cy_r[N][XW-1];
      km_fmag_r <= fmag_w[XW-2:0];
      km_lmag_r <= lmag_w[XW-2:0];

      pf_lo_r   <= 48'(km_fmag_r[17:0]) * 48'(vvu_pkg::KINV_Q30);
      pf_hi_r   <= 47'(km_fmag_r[XW-2:18]) * 47'(vvu_pkg::KINV_Q30);
      pl_lo_r   <= 48'(km_lmag_r[17:0]) * 48'(vvu_pkg::KINV_Q30);
      pl_hi_r   <= 47'(km_lmag_r[XW-2:18]) * 47'(vvu_pkg::KINV_Q30);
      pp_fneg_r <= km_fneg_r;
      pp_lneg_r <= km_lneg_r;

      proj_r.fneg <= pp_fneg_r;
      proj_r.fmag <= MW'(fsum_w >> 30);
      proj_r.lneg <= pp_lneg_r;
      proj_r.lmag <= MW'(lsum_w >> 30);
    end
  end

  // hold projections until the vector length is ready
  vvu_pkg::vvu_proj_t dly_r [1:DLY];

  for (genvar k = 1; k <= DLY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) dly_r[k] <= (k == 1) ? proj_r : dly_r[k == 1 ? 1 : k-1];
    end
  end

  // ---------------------------------------------------------------- length and clamp test
  logic [31:0] m2_r;
  logic        clamp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r    <= sqx_r + sqy_r;
      clamp_r <= (sqx_r + sqy_r) > 32'(lim_sq_r);
    end
  end

  // floor(sqrt(m2 * 2^32)), one root bit per stage
  logic [RW-1:0] sq_rem_r   [1:SQ];
  logic [31:0]   sq_root_r  [1:SQ];
  logic [31:0]   sq_rad_r   [1:SQ];
  logic          sq_clamp_r [1:SQ];

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    logic [RW-1:0] p_rem;
    logic [31:0]   p_root, p_rad;
    logic          p_clamp;
    logic [1:0]    pair;
    logic [RW+1:0] t, trial;

    if (j == 0) begin : g_first
      assign p_rem   = '0;
      assign p_root  = '0;
      assign p_rad   = m2_r;
      assign p_clamp = clamp_r;
    end else begin : g_next
      assign p_rem   = sq_rem_r[j];
      assign p_root  = sq_root_r[j];
      assign p_rad   = sq_rad_r[j];
      assign p_clamp = sq_clamp_r[j];
    end

    // the low half of the radicand is all zero
    if (j < 16) begin : g_hi
      assign pair = p_rad[31-2*j -: 2];
    end else begin : g_lo
      assign pair = 2'b00;
    end

    assign t     = {p_rem, pair};
    assign trial = {(RW-32)'(0), p_root, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= trial) begin
          sq_rem_r[j+1]  <= RW'(t - trial);
          sq_root_r[j+1] <= {p_root[30:0], 1'b1};
        end else begin
          sq_rem_r[j+1]  <= t[RW-1:0];
          sq_root_r[j+1] <= {p_root[30:0], 1'b0};
        end
        sq_rad_r[j+1]   <= p_rad;
        sq_clamp_r[j+1] <= p_clamp;
      end
    end
  end

  // ---------------------------------------------------------------- clamp rescale
  logic [47:0] nf_r, nl_r;
  logic [31:0] len_r;
  vvu_pkg::vvu_side_t sa_r, sb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nf_r       <= 48'(dly_r[DLY].fmag) * 48'(speed_limit_r);
      nl_r       <= 48'(dly_r[DLY].lmag) * 48'(speed_limit_r);
      len_r      <= sq_root_r[SQ];
      sa_r.clamp <= sq_clamp_r[SQ];
      sa_r.neg   <= dly_r[DLY].fneg;
      sa_r.mag   <= dly_r[DLY].fmag;
      sb_r.clamp <= sq_clamp_r[SQ];
      sb_r.neg   <= dly_r[DLY].lneg;
      sb_r.mag   <= dly_r[DLY].lmag;
    end
  end

  logic [vvu_pkg::CL_Q_W-1:0] qa, qb;
  logic [31:0] ra, rb, da, db;
  vvu_pkg::vvu_side_t sa_o, sb_o;

  vvu_div #(
    .NUM_W(64), .DEN_W(32), .Q_W(vvu_pkg::CL_Q_W), .SB_W($bits(vvu_pkg::vvu_side_t))
  ) u_div_fwd (
    .clk(clk), .en(en), .num_i({nf_r, 16'd0}), .den_i(len_r), .sb_i(sa_r),
    .quo_o(qa), .rem_o(ra), .den_o(da), .sb_o(sa_o)
  );

  vvu_div #(
    .NUM_W(64), .DEN_W(32), .Q_W(vvu_pkg::CL_Q_W), .SB_W($bits(vvu_pkg::vvu_side_t))
  ) u_div_lat (
    .clk(clk), .en(en), .num_i({nl_r, 16'd0}), .den_i(len_r), .sb_i(sb_r),
    .quo_o(qb), .rem_o(rb), .den_o(db), .sb_o(sb_o)
  );

  // round half up, pick the clamped or the raw component
  logic [MW-1:0] f2_r, l2_r;
  logic          f2_neg_r, l2_neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f2_r     <= sa_o.clamp ? MW'(qa) + MW'(ra >= da - ra) : sa_o.mag;
      l2_r     <= sb_o.clamp ? MW'(qb) + MW'(rb >= db - rb) : sb_o.mag;
      f2_neg_r <= sa_o.neg;
      l2_neg_r <= sb_o.neg;
    end
  end

  // ---------------------------------------------------------------- forward speed, degrees
  logic [MW-1:0] fr_w;
  logic [17:0]   fsm_w;
  logic [15:0]   fs_w;
  logic [38:0]   lp_lo_r, lp_hi_r;
  vvu_pkg::vvu_tail_t t1_r, t2_r;
  logic [vvu_pkg::TR_NUM_W-1:0] tn_r;

  assign fr_w  = f2_r + MW'(17'd32768);
  assign fsm_w = fr_w[33:16];

  always_comb begin
    if (f2_neg_r) fs_w = (fsm_w >= 18'd32768) ? 16'h8000 : 16'(-fsm_w);
    else          fs_w = (fsm_w > 18'd32767) ? 16'h7FFF : fsm_w[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lp_lo_r   <= 39'(l2_r[16:0]) * 39'(vvu_pkg::RAD2DEG_Q16);
      lp_hi_r   <= 39'(l2_r[MW-1:17]) * 39'(vvu_pkg::RAD2DEG_Q16);
      t1_r.lneg <= l2_neg_r;
      t1_r.fs   <= fs_w;

      tn_r <= vvu_pkg::TR_NUM_W'(lp_lo_r) + (vvu_pkg::TR_NUM_W'(lp_hi_r) << 17);
      t2_r <= t1_r;
    end
  end

  // ---------------------------------------------------------------- turn rate division
  logic [vvu_pkg::TR_Q_W-1:0]   qc;
  logic [vvu_pkg::TR_DEN_W-1:0] rc, dc;
  vvu_pkg::vvu_tail_t           tc;

  vvu_div #(
    .NUM_W(vvu_pkg::TR_NUM_W), .DEN_W(vvu_pkg::TR_DEN_W), .Q_W(vvu_pkg::TR_Q_W),
    .SB_W($bits(vvu_pkg::vvu_tail_t))
  ) u_div_turn (
    .clk(clk), .en(en), .num_i(tn_r), .den_i(tr_den_r), .sb_i(t2_r),
    .quo_o(qc), .rem_o(rc), .den_o(dc), .sb_o(tc)
  );

  logic [33:0] trm_w;
  logic [31:0] tr_w;

  assign trm_w = 34'(qc) + 34'(rc >= dc - rc);

  always_comb begin
    if (tc.lneg) tr_w = (trm_w >= 34'h080000000) ? 32'h80000000 : 32'(-trm_w);
    else         tr_w = (trm_w > 34'h07FFFFFFF) ? 32'h7FFFFFFF : trm_w[31:0];
  end

  // ---------------------------------------------------------------- output register
  logic [15:0] fs_out_r;
  logic [31:0] tr_out_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fs_out_r <= tc.fs;
      tr_out_r <= tr_w;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {tr_out_r, fs_out_r};

endmodule

### hw/rtl/vvu_checker.sv
`timescale 1ns / 1ps
// vvu_checker: port-level assertions for the converter, bound to the top level.
module vvu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // a stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // input is taken exactly when the pipe can advance
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow the output stall");

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word shown straight after reset");

endmodule

bind velocity_vector_to_unicycle vvu_checker u_vvu_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking stream test of velocity_vector_to_unicycle.
module testbench;

  // one command word and one unicycle result, in block widths
  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } command_t;

  typedef struct packed {
    logic signed [15:0] fwd_speed;
    logic signed [31:0] turn_rate;
  } motion_t;

  // directed row: known = 1 means the typed result is checked against the predictor too
  typedef struct packed {
    command_t cmd;
    logic     known;
    motion_t  res;
  } probe_t;

  localparam int LATENCY    = 106;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;
  localparam int RAND_ITEMS = 120;  // per setting, five settings

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [15:0] heading, [31:16] vel_x, [47:32] vel_y
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [15:0] forward_speed, [47:16] turn_rate
  logic        cfg_valid;
  logic        cfg_ready;
  vvu_pkg::vvu_reg_t cfg_addr;
  logic [15:0] cfg_data;

  // tb copy of the registers
  logic [14:0] lim_reg;
  logic [14:0] dist_reg;

  motion_t pending_motion[$];
  int      errors;
  int      idle_cycles;
  bit      hold_go;

  velocity_vector_to_unicycle uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned div_near(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    if (r >= den - r) q++;
    return q;
  endfunction

  function automatic longint div_near_signed(longint num, longint unsigned den);
    longint unsigned m, q;
    m = (num < 0) ? longint'(-num) : num;
    q = div_near(m, den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // shrink one component by limit / |v|, length given in Q.16
  function automatic longint shrink(longint c, longint unsigned lim, longint unsigned len_q16);
    longint unsigned m, q;
    m = (c < 0) ? longint'(-c) : c;
    q = div_near(m * lim * 64'd65536, len_q16);
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic motion_t to_unicycle(command_t c, logic [14:0] lim_r, logic [14:0] dist_r);
    longint x, y, z, ang, dx, dy, fwd, lat, vx, vy, fs, tr;
    longint unsigned m2, lim, tdist, len_q16;
    motion_t r;
    vx  = c.vel_x;
    vy  = c.vel_y;
    x   = vx * 65536;
    y   = vy * 65536;
    z   = longint'(c.heading) * 2048;
    lim = lim_r;
    tdist = (dist_r == 0) ? 1 : dist_r;
    // fold headings beyond a quarter turn back into CORDIC range
    if (z > longint'(vvu_pkg::HALF_PI_Q24)) begin
      z -= longint'(vvu_pkg::PI_Q24);
      x = -x;
      y = -y;
    end else if (z < -longint'(vvu_pkg::HALF_PI_Q24)) begin
      z += longint'(vvu_pkg::PI_Q24);
      x = -x;
      y = -y;
    end
    ang = -z;
    for (int i = 0; i < 16 && i < vvu_pkg::ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang >= 0) begin
        x -= dx;
        y += dy;
        ang -= longint'(vvu_pkg::ATAN_Q24[i]);
      end else begin
        x += dx;
        y -= dy;
        ang += longint'(vvu_pkg::ATAN_Q24[i]);
      end
    end
    fwd = div_near_signed(x * longint'(vvu_pkg::KINV_Q30), 64'd1 << 30);
    lat = div_near_signed(y * longint'(vvu_pkg::KINV_Q30), 64'd1 << 30);
    m2 = vx * vx + vy * vy;
    if (m2 > lim * lim) begin
      len_q16 = root_floor(m2 << 32);
      fwd = shrink(fwd, lim, len_q16);
      lat = shrink(lat, lim, len_q16);
    end
    fs = div_near_signed(fwd, 64'd65536);
    if (fs > 32767) fs = 32767;
    if (fs < -32768) fs = -32768;
    tr = div_near_signed(lat * longint'(vvu_pkg::RAD2DEG_Q16), tdist << 24);
    if (tr > 64'sd2147483647) tr = 64'sd2147483647;
    if (tr < -64'sd2147483648) tr = -64'sd2147483648;
    r.fwd_speed = fs[15:0];
    r.turn_rate = tr[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- monitors
  always @(posedge clk) begin
    motion_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pending_motion = {pending_motion,
                          to_unicycle(command_t'({in_tdata[15:0], in_tdata[31:16],
                                                  in_tdata[47:32]}), lim_reg, dist_reg)};
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[47:16]};
        if (pending_motion.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, actual fs=%0d tr=%0d", $time,
                   got.fwd_speed, got.turn_rate);
        end else begin
          want = pending_motion.pop_front();
          if (got.fwd_speed !== want.fwd_speed) begin
            errors++;
            $display("%0t: forward_speed expected %0d actual %0d", $time,
                     want.fwd_speed, got.fwd_speed);
          end
          if (got.turn_rate !== want.turn_rate) begin
            errors++;
            $display("%0t: turn_rate expected %0d actual %0d", $time,
                     want.turn_rate, got.turn_rate);
          end
        end
      end
    end
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d words outstanding", $time, pending_motion.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stretches of full readiness and stretches of random stalls,
  // plus one long hold-off on request so the pipe fills and in_tready drops
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- sender
  int burst_left;

  task automatic send_cmd(command_t c);
    in_tvalid <= 1'b1;
    in_tdata  <= {c.vel_y, c.vel_x, c.heading};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // burst over: drop valid for a random gap, two times in three
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(vvu_pkg::vvu_reg_t idx, logic [14:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= {1'b0, val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == vvu_pkg::REG_SPEED_LIMIT) lim_reg = val;
    else dist_reg = val;
    @(posedge clk);
  endtask

  // drain everything, then let the pipe empty before touching registers
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_motion.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic command_t random_cmd(logic [14:0] lim);
    command_t c;
    int span;
    c.heading = 16'($urandom);
    case ($urandom_range(0, 4))
      0, 1: begin
        // inside or near the speed limit
        span = (lim < 20) ? 20 : lim;
        c.vel_x = 16'($urandom_range(0, 2 * span) - span);
        c.vel_y = 16'($urandom_range(0, 2 * span) - span);
      end
      2: begin
        c.vel_x = 16'($urandom_range(0, 400) - 200);
        c.vel_y = 16'($urandom_range(0, 400) - 200);
      end
      3: begin
        c.vel_x = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
        c.vel_y = 16'($urandom);
      end
      default: begin
        c.vel_x = 16'($urandom);
        c.vel_y = 16'($urandom);
      end
    endcase
    return c;
  endfunction

  // directed rows: extremes, heading fold boundaries, limit edges
  probe_t probes[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 32'sd0}},            // zero vector
    '{'{16'sh7fff, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 32'sd0}},
    '{'{16'sh8000, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 32'sd0}},
    '{'{16'sd0, 16'sd50, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd50}, 1'b0, '0},
    '{'{16'sd0, 16'sd60, 16'sd80}, 1'b0, '0},                         // exactly on limit
    '{'{16'sd0, 16'sd60, 16'sd81}, 1'b0, '0},                         // just over
    '{'{16'sd12867, 16'sd30, 16'sd40}, 1'b0, '0},                     // below quarter turn
    '{'{16'sd12868, 16'sd30, 16'sd40}, 1'b0, '0},                     // folded
    '{'{-16'sd12867, 16'sd30, -16'sd40}, 1'b0, '0},
    '{'{-16'sd12868, 16'sd30, -16'sd40}, 1'b0, '0},
    '{'{16'sd25736, -16'sd70, 16'sd10}, 1'b0, '0},
    '{'{-16'sd25736, 16'sd5, -16'sd90}, 1'b0, '0},
    '{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0},
    '{'{16'sd0, 16'sh7fff, 16'sh8000}, 1'b0, '0},
    '{'{16'sd6434, 16'sh8000, 16'sd0}, 1'b0, '0},
    '{'{-16'sd6434, 16'sd0, 16'sh7fff}, 1'b0, '0},
    '{'{16'sd100, -16'sd1, 16'sd1}, 1'b0, '0}
  };

  task automatic run_probes();
    motion_t want;
    foreach (probes[i]) begin
      if (probes[i].known) begin
        want = to_unicycle(probes[i].cmd, lim_reg, dist_reg);
        if (want !== probes[i].res) begin
          errors++;
          $display("%0t: row %0d expected fs=%0d tr=%0d actual fs=%0d tr=%0d", $time, i,
                   probes[i].res.fwd_speed, probes[i].res.turn_rate,
                   want.fwd_speed, want.turn_rate);
        end
      end
      send_cmd(probes[i].cmd);
    end
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    logic [14:0] lim_set [5];
    logic [14:0] dist_set[5];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_addr   = vvu_pkg::REG_SPEED_LIMIT;
    cfg_data   = '0;
    lim_reg    = vvu_pkg::SPEED_LIMIT_RST;
    dist_reg   = vvu_pkg::TURN_DISTANCE_RST;
    errors     = 0;
    idle_cycles = 0;
    hold_go    = 1'b0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // settings: reset values, zero limit and distance, both maxima, unit distance, mid
    lim_set  = '{vvu_pkg::SPEED_LIMIT_RST, 15'd0, 15'h7fff, 15'h7fff, 15'd0};
    dist_set = '{vvu_pkg::TURN_DISTANCE_RST, 15'd0, 15'h7fff, 15'd1, 15'd0};
    lim_set[4]  = 15'($urandom_range(1, 3000));
    dist_set[4] = 15'($urandom_range(2, 500));

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        settle();
        write_reg(vvu_pkg::REG_SPEED_LIMIT, lim_set[p]);
        write_reg(vvu_pkg::REG_TURN_DISTANCE, dist_set[p]);
      end
      if (p < 3) run_probes();
      for (int n = 0; n < RAND_ITEMS; n++) begin
        if (p == 2 && n == 10) hold_go = 1'b1;
        send_cmd(random_cmd(lim_reg));
      end
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### velocity_vector_to_unicycle.f
hw/rtl/vvu_pkg.sv
hw/rtl/vvu_div.sv
hw/rtl/velocity_vector_to_unicycle.sv
hw/rtl/vvu_checker.sv
tb/testbench.sv
